FILE: design/sqm_pkg.sv
// ----------------------------------------------------------------------------
// sqm_pkg: shared types and constants of the quad mesh connectivity unit
// Field widths, register indexes, cell codes and the pipeline side-band.
// ----------------------------------------------------------------------------
`default_nettype none

package sqm_pkg;

    localparam int MAX_CELLS_SIDE_DEF = 1024;

    localparam int CELL_W   = 11;               // cells_x / cells_y register width
    localparam int CELL_MAX = 2**CELL_W - 1;
    localparam int SUM_W    = CELL_W + 1;       // nx + ny
    localparam int EDGE_W   = CELL_W + 2;       // 2 * (nx + ny)
    localparam int AREA_W   = 2 * CELL_W;       // nx * ny
    localparam int PITCH_W  = CELL_W + 2;       // node row pitch, up to 4*nx+2
    localparam int MUL_W    = CELL_W + PITCH_W;
    localparam int POS_W    = 21;
    localparam int NODE_W   = 23;
    localparam int TOTAL_W  = 23;
    localparam int CNT_W    = 4;
    localparam int CODE_W   = 5;
    localparam int NODES    = 9;

    // divider: one quotient bit per step, DIV_BITS steps per stage (fewer in the last)
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = (CELL_W + DIV_BITS - 1) / DIV_BITS;

    // configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_KIND    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CELLS_X = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CELLS_Y = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LINE2 = 4'd2;
    localparam logic [CNT_W-1:0] CNT_LINE3 = 4'd3;
    localparam logic [CNT_W-1:0] CNT_QUAD4 = 4'd4;
    localparam logic [CNT_W-1:0] CNT_QUAD8 = 4'd8;
    localparam logic [CNT_W-1:0] CNT_QUAD9 = 4'd9;

    localparam logic [CODE_W-1:0] CODE_LINE2 = 5'd3;
    localparam logic [CODE_W-1:0] CODE_LINE3 = 5'd4;
    localparam logic [CODE_W-1:0] CODE_QUAD4 = 5'd9;
    localparam logic [CODE_W-1:0] CODE_QUAD8 = 5'd23;
    localparam logic [CODE_W-1:0] CODE_QUAD9 = 5'd28;

    typedef enum logic [1:0] {
        KIND_QUAD4 = 2'd0,
        KIND_QUAD8 = 2'd1,
        KIND_QUAD9 = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_TOP    = 2'd3
    } t_side;

    typedef logic [NODE_W-1:0] t_node;

    // travels with each request alongside the divider
    typedef struct packed {
        logic              beyond;
        logic              is_edge;
        t_side             side;
        logic [CELL_W-1:0] rm1;     // row - 1 of the adjacent bulk cell
        logic [CELL_W-1:0] cm1;     // column - 1
    } t_meta;

endpackage

`default_nettype wire

FILE: design/sqm_div.sv
// ----------------------------------------------------------------------------
// sqm_div: pipelined restoring divider
// Splits a bulk offset into row and column by the cell column count,
// DIV_BITS quotient bits per stage (fewer in the last), with a side-band that rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module sqm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [sqm_pkg::POS_W-1:0]   i_dividend,
    input  logic [sqm_pkg::CELL_W-1:0]  i_divisor,
    input  sqm_pkg::t_meta              i_meta,
    output logic                        o_valid,
    output logic [sqm_pkg::CELL_W-1:0]  o_quot,
    output logic [sqm_pkg::CELL_W-1:0]  o_rem,
    output sqm_pkg::t_meta              o_meta
);
    import sqm_pkg::*;

    logic              r_valid [DIV_STAGES];
    logic [POS_W-1:0]  r_rem   [DIV_STAGES];
    logic [CELL_W-1:0] r_quot  [DIV_STAGES];
    t_meta             r_meta  [DIV_STAGES];

    logic              w_valid_in [DIV_STAGES];
    logic [POS_W-1:0]  w_rem_in   [DIV_STAGES];
    logic [CELL_W-1:0] w_quot_in  [DIV_STAGES];
    t_meta             w_meta_in  [DIV_STAGES];

    logic [POS_W-1:0]  n_rem  [DIV_STAGES];
    logic [CELL_W-1:0] n_quot [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_link
        if (s == 0) begin : g_first
            assign w_valid_in[s] = i_valid;
            assign w_rem_in[s]   = i_dividend;
            assign w_quot_in[s]  = '0;
            assign w_meta_in[s]  = i_meta;
        end else begin : g_next
            assign w_valid_in[s] = r_valid[s-1];
            assign w_rem_in[s]   = r_rem[s-1];
            assign w_quot_in[s]  = r_quot[s-1];
            assign w_meta_in[s]  = r_meta[s-1];
        end
    end

    // quotient bits come out MSB first and shift in from the right
    always_comb begin
        logic [POS_W-1:0]  v_rem;
        logic [CELL_W-1:0] v_quot;
        logic [POS_W-1:0]  v_dvs;
        logic              v_ge;
        int                b;
        for (int s = 0; s < DIV_STAGES; s++) begin
            v_rem  = w_rem_in[s];
            v_quot = w_quot_in[s];
            for (int j = 0; j < DIV_BITS; j++) begin
                b = CELL_W - 1 - s * DIV_BITS - j;
                if (b >= 0) begin
                    v_dvs  = POS_W'(i_divisor) << b;
                    v_ge   = (v_rem >= v_dvs);
                    if (v_ge) begin
                        v_rem = v_rem - v_dvs;
                    end
                    v_quot = {v_quot[CELL_W-2:0], v_ge};
                end
            end
            n_rem[s]  = v_rem;
            n_quot[s] = v_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_valid[s] <= w_valid_in[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_rem[s]  <= n_rem[s];
            r_quot[s] <= n_quot[s];
            r_meta[s] <= w_meta_in[s];
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_quot  = r_quot[DIV_STAGES-1];
    assign o_rem   = r_rem[DIV_STAGES-1][CELL_W-1:0];
    assign o_meta  = r_meta[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: design/structured_quad_mesh_connectivity_unit.sv
// ----------------------------------------------------------------------------
// structured_quad_mesh_connectivity_unit: element lookup of a structured quad mesh
// Pipeline: a request taken at a rising edge passes through 2 stages of range
//   check and side classification, 4 divider stages, 1 multiply stage and 3
//   node/selection stages before its result shows with o_done high.
// Throughput: one request per cycle; busy never rises, the pipeline has no stall.
// Reset clears the pipeline valid bits and sets kind 0, cells_x = cells_y = 1.
// ----------------------------------------------------------------------------
`default_nettype none

module structured_quad_mesh_connectivity_unit #(
    parameter int MAX_CELLS_SIDE = sqm_pkg::MAX_CELLS_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sqm_pkg::ADDR_W-1:0]  paddr,
    input  logic [sqm_pkg::DATA_W-1:0]  pwdata,
    output logic [sqm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [sqm_pkg::POS_W-1:0]   i_element_position,
    output logic                        o_done,
    output logic                        o_beyond_range,
    output logic [sqm_pkg::CNT_W-1:0]   o_node_count,
    output logic [sqm_pkg::CODE_W-1:0]  o_cell_code,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_a,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_b,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_c,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_d,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_e,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_f,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_g,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_h,
    output logic [sqm_pkg::NODE_W-1:0]  o_node_i
);
    import sqm_pkg::*;

    localparam int CLAMP_MAX = (MAX_CELLS_SIDE > CELL_MAX) ? CELL_MAX : MAX_CELLS_SIDE;
    localparam logic [CELL_W-1:0] CLAMP_V = CELL_W'(CLAMP_MAX);
    localparam int LATENCY = DIV_STAGES + 6;

    // ---------------- configuration registers ----------------
    t_kind                r_kind;
    logic [CELL_W-1:0]    r_cells_x;
    logic [CELL_W-1:0]    r_cells_y;
    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready   = 1'b1;
    assign busy     = 1'b0;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign w_idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_QUAD4;
            r_cells_x <= CELL_W'(1);
            r_cells_y <= CELL_W'(1);
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_KIND:    r_kind    <= t_kind'(pwdata[1:0]);
                REG_CELLS_X: r_cells_x <= pwdata[CELL_W-1:0];
                REG_CELLS_Y: r_cells_y <= pwdata[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_KIND:    prdata = DATA_W'(r_kind);
            REG_CELLS_X: prdata = DATA_W'(r_cells_x);
            REG_CELLS_Y: prdata = DATA_W'(r_cells_y);
            default:     prdata = '0;
        endcase
    end

    function automatic logic [CELL_W-1:0] clamp_cells(input logic [CELL_W-1:0] v);
        if (v == '0) return CELL_W'(1);
        if (v > CLAMP_V) return CLAMP_V;
        return v;
    endfunction

    logic [CELL_W-1:0] w_nx;
    logic [CELL_W-1:0] w_ny;
    assign w_nx = clamp_cells(r_cells_x);
    assign w_ny = clamp_cells(r_cells_y);

    // ---------------- stage A: take request, area ----------------
    logic              r_a_valid;
    logic [POS_W-1:0]  r_a_pos;
    logic [AREA_W-1:0] r_a_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else          r_a_valid <= start & ~busy;
    end

    always_ff @(posedge i_clk) begin
        r_a_pos  <= i_element_position;
        r_a_area <= AREA_W'(w_nx) * AREA_W'(w_ny);
    end

    // ---------------- stage B: range check, side ----------------
    logic [SUM_W-1:0]   w_sum;
    logic [EDGE_W-1:0]  w_edges;
    logic [TOTAL_W-1:0] w_total;
    logic [POS_W-1:0]   w_ny_p;
    logic [POS_W-1:0]   w_2ny;
    logic [POS_W-1:0]   w_lim_b;
    logic [POS_W-1:0]   w_edges_p;
    logic [POS_W-1:0]   w_d_right;
    logic [POS_W-1:0]   w_d_bottom;
    logic [POS_W-1:0]   w_d_top;
    t_meta              n_b_meta;

    assign w_sum      = SUM_W'(w_nx) + SUM_W'(w_ny);
    assign w_edges    = {w_sum, 1'b0};
    assign w_total    = TOTAL_W'(r_a_area) + TOTAL_W'(w_edges);
    assign w_ny_p     = POS_W'(w_ny);
    assign w_2ny      = POS_W'({w_ny, 1'b0});
    assign w_lim_b    = w_2ny + POS_W'(w_nx);
    assign w_edges_p  = POS_W'(w_edges);
    assign w_d_right  = r_a_pos - w_ny_p;
    assign w_d_bottom = r_a_pos - w_2ny;
    assign w_d_top    = r_a_pos - w_lim_b;

    always_comb begin
        n_b_meta.beyond  = (r_kind == KIND_NONE) || (TOTAL_W'(r_a_pos) >= w_total);
        n_b_meta.is_edge = 1'b1;
        n_b_meta.side    = SIDE_LEFT;
        n_b_meta.rm1     = '0;
        n_b_meta.cm1     = '0;
        priority if (r_a_pos < w_ny_p) begin
            n_b_meta.rm1  = r_a_pos[CELL_W-1:0];
        end else if (r_a_pos < w_2ny) begin
            n_b_meta.side = SIDE_RIGHT;
            n_b_meta.rm1  = w_d_right[CELL_W-1:0];
            n_b_meta.cm1  = w_nx - CELL_W'(1);
        end else if (r_a_pos < w_lim_b) begin
            n_b_meta.side = SIDE_BOTTOM;
            n_b_meta.cm1  = w_d_bottom[CELL_W-1:0];
        end else if (r_a_pos < w_edges_p) begin
            n_b_meta.side = SIDE_TOP;
            n_b_meta.rm1  = w_ny - CELL_W'(1);
            n_b_meta.cm1  = w_d_top[CELL_W-1:0];
        end else begin
            n_b_meta.is_edge = 1'b0;
        end
    end

    logic             r_b_valid;
    t_meta            r_b_meta;
    logic [POS_W-1:0] r_b_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_valid <= 1'b0;
        else          r_b_valid <= r_a_valid;
    end

    always_ff @(posedge i_clk) begin
        r_b_meta <= n_b_meta;
        r_b_q    <= r_a_pos - w_edges_p;   // bulk offset
    end

    // ---------------- divider: row and column of bulk cells ----------------
    logic              d_valid;
    logic [CELL_W-1:0] d_quot;
    logic [CELL_W-1:0] d_rem;
    t_meta             d_meta;

    sqm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_b_valid),
        .i_dividend (r_b_q),
        .i_divisor  (w_nx),
        .i_meta     (r_b_meta),
        .o_valid    (d_valid),
        .o_quot     (d_quot),
        .o_rem      (d_rem),
        .o_meta     (d_meta)
    );

    // ---------------- stage M: row base ----------------
    logic [CELL_W-1:0]  w_row;
    logic [CELL_W-1:0]  w_col;
    logic [PITCH_W-1:0] w_pitch;
    logic [MUL_W-1:0]   w_prod;

    assign w_row = d_meta.is_edge ? d_meta.rm1 : d_quot;
    assign w_col = d_meta.is_edge ? d_meta.cm1 : d_rem;

    always_comb begin
        unique case (r_kind)
            KIND_QUAD4: w_pitch = PITCH_W'(w_nx) + PITCH_W'(1);
            KIND_QUAD8: w_pitch = PITCH_W'({w_nx, 1'b0}) + PITCH_W'(w_nx) + PITCH_W'(2);
            KIND_QUAD9: w_pitch = PITCH_W'({w_nx, 2'b00}) + PITCH_W'(2);
            KIND_NONE:  w_pitch = '0;
        endcase
    end

    assign w_prod = MUL_W'(w_row) * MUL_W'(w_pitch);

    logic               r_m_valid;
    t_meta              r_m_meta;
    t_node              r_m_base;
    logic [CELL_W-1:0]  r_m_col;
    logic [PITCH_W-1:0] r_m_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_valid <= 1'b0;
        else          r_m_valid <= d_valid;
    end

    always_ff @(posedge i_clk) begin
        r_m_meta  <= d_meta;
        r_m_base  <= w_prod[NODE_W-1:0];
        r_m_col   <= w_col;
        r_m_pitch <= w_pitch;
    end

    // ---------------- stage F: first corner and left mid-side ----------------
    t_node w_col_n;
    t_node w_nx_n;
    t_node n_f_n1;
    t_node n_f_n8;

    assign w_col_n = NODE_W'(r_m_col);
    assign w_nx_n  = NODE_W'(w_nx);

    always_comb begin
        unique case (r_kind)
            KIND_QUAD4: begin
                n_f_n1 = r_m_base + w_col_n + NODE_W'(1);
                n_f_n8 = '0;
            end
            KIND_QUAD8: begin
                n_f_n1 = r_m_base + (w_col_n << 1) + NODE_W'(1);
                n_f_n8 = r_m_base + (w_nx_n << 1) + w_col_n + NODE_W'(2);
            end
            KIND_QUAD9: begin
                n_f_n1 = r_m_base + (w_col_n << 1) + NODE_W'(1);
                n_f_n8 = r_m_base + (w_nx_n << 1) + (w_col_n << 1) + NODE_W'(2);
            end
            KIND_NONE: begin
                n_f_n1 = '0;
                n_f_n8 = '0;
            end
        endcase
    end

    logic               r_f_valid;
    t_meta              r_f_meta;
    t_node              r_f_n1;
    t_node              r_f_n8;
    logic [PITCH_W-1:0] r_f_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_valid <= 1'b0;
        else          r_f_valid <= r_m_valid;
    end

    always_ff @(posedge i_clk) begin
        r_f_meta  <= r_m_meta;
        r_f_n1    <= n_f_n1;
        r_f_n8    <= n_f_n8;
        r_f_pitch <= r_m_pitch;
    end

    // ---------------- stage G: all nine nodes of the cell ----------------
    t_node w_step;
    t_node w_p;
    t_node n_g_n [NODES];

    // corner step along x: 1 on the four-node grid, 2 on the others
    assign w_step = (r_kind == KIND_QUAD4) ? NODE_W'(1) : NODE_W'(2);
    assign w_p    = NODE_W'(r_f_pitch);

    always_comb begin
        n_g_n[0] = r_f_n1;
        n_g_n[1] = r_f_n1 + w_step;
        n_g_n[2] = r_f_n1 + w_step + w_p;
        n_g_n[3] = r_f_n1 + w_p;
        n_g_n[4] = r_f_n1 + NODE_W'(1);
        n_g_n[5] = r_f_n8 + ((r_kind == KIND_QUAD8) ? NODE_W'(1) : NODE_W'(2));
        n_g_n[6] = r_f_n1 + w_step + w_p - NODE_W'(1);
        n_g_n[7] = r_f_n8;
        n_g_n[8] = r_f_n8 + NODE_W'(1);
    end

    logic  r_g_valid;
    t_meta r_g_meta;
    t_node r_g_n [NODES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_valid <= 1'b0;
        else          r_g_valid <= r_f_valid;
    end

    always_ff @(posedge i_clk) begin
        r_g_meta <= r_f_meta;
        for (int k = 0; k < NODES; k++) begin
            r_g_n[k] <= n_g_n[k];
        end
    end

    // ---------------- stage O: pick slots, output register ----------------
    t_node             n_o_node [NODES];
    logic [CNT_W-1:0]  n_o_count;
    logic [CODE_W-1:0] n_o_code;

    always_comb begin
        t_node v_first;
        t_node v_mid;
        t_node v_last;
        for (int k = 0; k < NODES; k++) begin
            n_o_node[k] = '0;
        end
        n_o_count = '0;
        n_o_code  = '0;
        unique case (r_g_meta.side)
            SIDE_LEFT: begin
                v_first = r_g_n[3]; v_mid = r_g_n[7]; v_last = r_g_n[0];
            end
            SIDE_RIGHT: begin
                v_first = r_g_n[1]; v_mid = r_g_n[5]; v_last = r_g_n[2];
            end
            SIDE_BOTTOM: begin
                v_first = r_g_n[0]; v_mid = r_g_n[4]; v_last = r_g_n[1];
            end
            SIDE_TOP: begin
                v_first = r_g_n[2]; v_mid = r_g_n[6]; v_last = r_g_n[3];
            end
        endcase
        if (!r_g_meta.beyond) begin
            if (r_g_meta.is_edge) begin
                n_o_node[0] = v_first;
                if (r_kind == KIND_QUAD4) begin
                    n_o_node[1] = v_last;
                    n_o_count   = CNT_LINE2;
                    n_o_code    = CODE_LINE2;
                end else begin
                    n_o_node[1] = v_mid;
                    n_o_node[2] = v_last;
                    n_o_count   = CNT_LINE3;
                    n_o_code    = CODE_LINE3;
                end
            end else begin
                unique case (r_kind)
                    KIND_QUAD4: begin
                        for (int k = 0; k < 4; k++) n_o_node[k] = r_g_n[k];
                        n_o_count = CNT_QUAD4;
                        n_o_code  = CODE_QUAD4;
                    end
                    KIND_QUAD8: begin
                        for (int k = 0; k < 8; k++) n_o_node[k] = r_g_n[k];
                        n_o_count = CNT_QUAD8;
                        n_o_code  = CODE_QUAD8;
                    end
                    KIND_QUAD9: begin
                        for (int k = 0; k < NODES; k++) n_o_node[k] = r_g_n[k];
                        n_o_count = CNT_QUAD9;
                        n_o_code  = CODE_QUAD9;
                    end
                    KIND_NONE: ;    // always beyond range
                endcase
            end
        end
    end

    logic              r_o_valid;
    logic              r_o_beyond;
    logic [CNT_W-1:0]  r_o_count;
    logic [CODE_W-1:0] r_o_code;
    t_node             r_o_node [NODES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else          r_o_valid <= r_g_valid;
    end

    always_ff @(posedge i_clk) begin
        r_o_beyond <= r_g_meta.beyond;
        r_o_count  <= n_o_count;
        r_o_code   <= n_o_code;
        for (int k = 0; k < NODES; k++) begin
            r_o_node[k] <= n_o_node[k];
        end
    end

    assign o_done         = r_o_valid;
    assign o_beyond_range = r_o_beyond;
    assign o_node_count   = r_o_count;
    assign o_cell_code    = r_o_code;
    assign o_node_a       = r_o_node[0];
    assign o_node_b       = r_o_node[1];
    assign o_node_c       = r_o_node[2];
    assign o_node_d       = r_o_node[3];
    assign o_node_e       = r_o_node[4];
    assign o_node_f       = r_o_node[5];
    assign o_node_g       = r_o_node[6];
    assign o_node_h       = r_o_node[7];
    assign o_node_i       = r_o_node[8];

    // ---------------- assertions ----------------
    logic w_accept;
    assign w_accept = start & ~busy;

    a_request_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_done)
        else $error("request did not produce a result at the expected cycle");

    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching request");

    a_beyond_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_beyond_range) |-> (o_node_count == '0 && o_cell_code == '0 &&
            o_node_a == '0 && o_node_b == '0 && o_node_i == '0))
        else $error("out-of-range result carries nonzero fields");

endmodule

`default_nettype wire
